// File: rtl/psc_pkg.sv
// Shared types, constants and register indexes of the priority counting semaphore.
package psc_pkg;

  localparam int PSC_QUEUE_DEPTH = 16;
  localparam int PSC_TASK_COUNT  = 32;

  localparam int ID_W     = 5;
  localparam int PRIO_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_REFUSED = 2'd2,
    ST_HANDED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t item;
  } ctrl_t;

endpackage

// File: rtl/psc_req_if.sv
// Request channel: take and give operations.
interface psc_req_if
  import psc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] task_prio;
  logic              wait_req;

  modport source (output valid, output mode, output task_id, output task_prio,
                  output wait_req, input ready);
  modport sink   (input valid, input mode, input task_id, input task_prio,
                  input wait_req, output ready);
endinterface

// File: rtl/psc_rsp_if.sv
// Response channel: status and woken task.
interface psc_rsp_if
  import psc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [ID_W-1:0] woken_task;

  modport source (output valid, output status, output woken_task, input ready);
  modport sink   (input valid, input status, input woken_task, output ready);
endinterface

// File: rtl/psc_cell.sv
// One slot of the shift-register wait queue.
module psc_cell
  import psc_pkg::*;
(
  input  logic   clk,
  input  ctrl_t  ctrl,
  input  logic   occupied,
  input  logic   left_keep,
  input  entry_t left_item,
  input  entry_t right_item,
  output logic   keep,
  output entry_t item
);

  entry_t item_next;

  assign keep = occupied && (item.prio <= ctrl.item.prio);

  always_comb begin
    item_next = item;
    if (ctrl.insert) begin
      if (keep) begin
        item_next = item;
      end else if (left_keep) begin
        item_next = ctrl.item;
      end else begin
        item_next = left_item;
      end
    end else if (ctrl.pop) begin
      item_next = right_item;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

// File: rtl/priority_counting_semaphore_top.sv
// Top level of the priority counting semaphore.
//
//  channel | direction | transfer moves
//  req     | in        | mode, task_id, task_prio, wait_req
//  rsp     | out       | status, woken_task
//  cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One request per cycle unless a stalled response holds req; its response is registered and appears the cycle after.
// The queue is a row of QUEUE_DEPTH cells that insert or shift together.
// Reset (rst, synchronous) clears count, queue fill and blocked marks; no clearing pass.
// A stalled response holds; req accepts whenever the response register is empty or drains.
module priority_counting_semaphore_top
  import psc_pkg::*;
#(
  parameter int QUEUE_DEPTH = PSC_QUEUE_DEPTH,
  parameter int TASK_COUNT  = PSC_TASK_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  psc_req_if.sink               req,
  psc_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int QW     = $clog2(QUEUE_DEPTH + 1);
  localparam int TIDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  logic [COUNT_W-1:0]    max_count;
  logic [COUNT_W-1:0]    sem_count;
  logic [COUNT_W-1:0]    sem_count_next;
  logic [QW-1:0]         waiter_total;
  logic [QW-1:0]         waiter_total_next;
  logic [TASK_COUNT-1:0] blocked;
  logic [TASK_COUNT-1:0] blocked_next;
  logic                  out_valid;
  status_t               out_status;
  logic [ID_W-1:0]       out_woken;
  status_t               status_next;
  logic [ID_W-1:0]       woken_next;

  logic                  accept;
  logic                  id_ok;
  logic                  is_blocked;
  logic                  full;
  logic                  head_ok;
  ctrl_t                 ctrl;
  logic                  keep_vec [QUEUE_DEPTH];
  entry_t                items    [QUEUE_DEPTH];

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign id_ok      = 32'(req.task_id) < 32'(TASK_COUNT);
  assign is_blocked = id_ok && blocked[TIDX_W'(req.task_id)];
  assign full       = waiter_total == QW'(QUEUE_DEPTH);
  assign head_ok    = 32'(items[0].id) < 32'(TASK_COUNT);

  always_comb begin
    sem_count_next    = sem_count;
    waiter_total_next = waiter_total;
    blocked_next      = blocked;
    status_next       = ST_REFUSED;
    woken_next        = '0;
    ctrl.insert       = 1'b0;
    ctrl.pop          = 1'b0;
    ctrl.item.id      = req.task_id;
    ctrl.item.prio    = req.task_prio;
    if (accept) begin
      if (!req.mode) begin
        if (sem_count != '0) begin
          sem_count_next = sem_count - COUNT_W'(1);
          status_next    = ST_OK;
        end else if (req.wait_req && id_ok && !is_blocked && !full) begin
          ctrl.insert                          = 1'b1;
          blocked_next[TIDX_W'(req.task_id)]   = 1'b1;
          waiter_total_next                    = waiter_total + QW'(1);
          status_next                          = ST_QUEUED;
        end
      end else begin
        if (waiter_total != '0) begin
          ctrl.pop          = 1'b1;
          waiter_total_next = waiter_total - QW'(1);
          woken_next        = items[0].id;
          status_next       = ST_HANDED;
          if (head_ok) begin
            blocked_next[TIDX_W'(items[0].id)] = 1'b0;
          end
        end else if (sem_count < max_count) begin
          sem_count_next = sem_count + COUNT_W'(1);
          status_next    = ST_OK;
        end
      end
    end
    if (cfg_we && cfg_index == REG_INITIAL_COUNT) begin
      sem_count_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count     <= COUNT_W'(1);
      sem_count     <= '0;
      waiter_total  <= '0;
      blocked       <= '0;
      out_valid     <= 1'b0;
    end else begin
      sem_count    <= sem_count_next;
      waiter_total <= waiter_total_next;
      blocked      <= blocked_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_COUNT: begin
            max_count <= cfg_data;
          end
          default: begin
            max_count <= max_count;
          end
        endcase
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_woken  <= woken_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.woken_task = out_woken;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occupied;
    logic   left_keep;
    entry_t left_item;
    entry_t right_item;

    assign occupied = waiter_total > QW'(i);

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_item = ctrl.item;
    end else begin : g_rest
      assign left_keep = keep_vec[i-1];
      assign left_item = items[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_item = items[i];
    end else begin : g_inner
      assign right_item = items[i+1];
    end

    psc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .left_keep  (left_keep),
      .left_item  (left_item),
      .right_item (right_item),
      .keep       (keep_vec[i]),
      .item       (items[i])
    );
  end

endmodule

// File: rtl/psc_checker.sv
// Port-level assertions for the priority counting semaphore, bound to the top level.
module psc_checker
  import psc_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input logic [1:0]      rsp_status,
  input logic [ID_W-1:0] rsp_woken_task
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid straight after reset");

  a_accept_gives_rsp : assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request produced no response");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty response register");

  a_woken_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_HANDED) |-> rsp_woken_task == '0)
    else $error("woken task nonzero without a hand-over");

  a_rsp_hold : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_woken_task))
    else $error("stalled response changed");

endmodule

bind priority_counting_semaphore_top psc_checker u_psc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_woken_task (rsp.woken_task)
);

// File: tb/psc_tb_pkg.sv
// Scoreboard class for the priority counting semaphore testbench: semaphore predictor and outcome store.
`timescale 1ns / 1ps
package psc_tb_pkg;
  import psc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(3);

  typedef struct {
    status_t         status;
    logic [ID_W-1:0] woken;
  } sem_outcome_t;

  class sem_scoreboard;
    logic [COUNT_W-1:0] init_count;
    logic [COUNT_W-1:0] max_count;
    logic [COUNT_W-1:0] sem_count;
    entry_t             waiters[PSC_QUEUE_DEPTH];
    int unsigned        waiting;
    bit                 blocked[PSC_TASK_COUNT];
    sem_outcome_t       outcomes_q[$];
    int unsigned        mismatches;

    function new();
      init_count = '0;
      max_count  = COUNT_W'(1);
      sem_count  = '0;
      waiting    = 0;
      mismatches = 0;
      foreach (blocked[i]) blocked[i] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_INITIAL_COUNT) begin
        init_count = val;
        sem_count  = val;
      end else if (idx == REG_MAX_COUNT) begin
        max_count = val;
      end
    endfunction

    function void note_request(logic mode, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                               logic may_wait);
      sem_outcome_t res;
      int unsigned  pos;
      res.status = ST_OK;
      res.woken  = '0;
      if (mode == 1'b0) begin
        if (sem_count != 0) begin
          sem_count = sem_count - 1'b1;
        end else if (!may_wait || blocked[id] || waiting >= PSC_QUEUE_DEPTH) begin
          res.status = ST_REFUSED;
        end else begin
          blocked[id] = 1'b1;
          pos = 0;
          while (pos < waiting && waiters[pos].prio <= prio) pos++;
          for (int k = waiting; k > pos; k--) waiters[k] = waiters[k-1];
          waiters[pos].id   = id;
          waiters[pos].prio = prio;
          waiting++;
          res.status = ST_QUEUED;
        end
      end else begin
        if (waiting != 0) begin
          res.woken = waiters[0].id;
          for (int k = 1; k < waiting; k++) waiters[k-1] = waiters[k];
          waiting--;
          blocked[res.woken] = 1'b0;
          res.status = ST_HANDED;
        end else if (sem_count >= max_count) begin
          res.status = ST_REFUSED;
        end else begin
          sem_count = sem_count + 1'b1;
        end
      end
      outcomes_q.push_back(res);
    endfunction

    function void check_response(logic [1:0] status, logic [ID_W-1:0] woken);
      sem_outcome_t want;
      if (outcomes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response with nothing outstanding: status %0d woken %0d",
                   $realtime, status, woken);
        return;
      end
      want = outcomes_q.pop_front();
      if (status !== want.status || woken !== want.woken) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected status %0d woken %0d, got status %0d woken %0d",
                   $realtime, want.status, want.woken, status, woken);
      end
    endfunction

    function int unsigned pending();
      return outcomes_q.size();
    endfunction
  endclass

endpackage

// File: tb/priority_counting_semaphore_top_test.sv
// Top-level testbench of the priority counting semaphore: stimulus, handshake idling and checks.
`timescale 1ns / 1ps
module priority_counting_semaphore_top_test;
  import psc_pkg::*;
  import psc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  sem_scoreboard sb;

  psc_req_if req();
  psc_rsp_if rsp();

  priority_counting_semaphore_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // hold ready low for bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(0, 11);
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) sb.check_response(rsp.status, rsp.woken_task);
      if (req.valid && req.ready)
        sb.note_request(req.mode, req.task_id, req.task_prio, req.wait_req);
    end
  end

  task automatic send_item(input logic mode, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input logic may_wait);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.mode      <= mode;
    req.task_id   <= id;
    req.task_prio <= prio;
    req.wait_req  <= may_wait;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic send_take(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                           input logic may_wait);
    send_item(1'b0, id, prio, may_wait);
  endtask

  task automatic send_give();
    send_item(1'b1, ID_W'($urandom), PRIO_W'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_IDX_W-1:0] idx_a,
                              input logic [CFG_DATA_W-1:0] val_a,
                              input logic [CFG_IDX_W-1:0] idx_b,
                              input logic [CFG_DATA_W-1:0] val_b);
    cfg_we    <= 1'b1;
    cfg_index <= idx_a;
    cfg_data  <= val_a;
    @(posedge clk);
    cfg_index <= idx_b;
    cfg_data  <= val_b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx_a, val_a);
    sb.write_reg(idx_b, val_b);
  endtask

  task automatic run_random(input int unsigned n, input int unsigned take_pct,
                            input int unsigned pause_at);
    logic [PRIO_W-1:0] prio;
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_at != 0 && i == pause_at) wait_drained();
      if ($urandom_range(99) < take_pct) begin
        prio = ($urandom_range(1) == 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
        send_take(ID_W'($urandom), prio, $urandom_range(99) < 85);
      end else begin
        send_give();
      end
    end
  endtask

  // offer every task id so the queue overflows, then drain it
  task automatic fill_and_drain();
    for (int unsigned i = 0; i < PSC_TASK_COUNT; i++)
      send_take(ID_W'(i), PRIO_W'($urandom_range(0, 7)), 1'b1);
    repeat (PSC_QUEUE_DEPTH + 4) send_give();
  endtask

  initial begin
    req.valid     = 1'b0;
    req.mode      = 1'b0;
    req.task_id   = '0;
    req.task_prio = '0;
    req.wait_req  = 1'b0;
    rsp.ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_INITIAL_COUNT;
    cfg_data      = '0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_give();
    send_give();
    send_take(ID_W'(0), PRIO_W'(0), 1'b1);
    send_take(ID_W'(1), PRIO_W'(0), 1'b0);
    send_take(ID_W'(0), PRIO_W'(255), 1'b1);
    send_take(ID_W'(31), PRIO_W'(0), 1'b1);
    send_take(ID_W'(31), PRIO_W'(10), 1'b1);
    send_take(ID_W'(5), PRIO_W'(0), 1'b1);
    send_take(ID_W'(10), PRIO_W'(255), 1'b1);
    repeat (5) send_give();

    wait_drained();
    program_regs(REG_INITIAL_COUNT, 8'd0, REG_MAX_COUNT, 8'd255);
    send_gap_pct = 15;
    stall_pct    = 15;
    fill_and_drain();
    run_random(280, 60, 140);

    wait_drained();
    program_regs(REG_INITIAL_COUNT, 8'd255, REG_MAX_COUNT, 8'd255);
    send_gap_pct = 30;
    stall_pct    = 5;
    run_random(200, 80, 0);

    wait_drained();
    program_regs(REG_MAX_COUNT, 8'd2, REG_INITIAL_COUNT, 8'd5);
    send_gap_pct = 0;
    stall_pct    = 0;
    run_random(200, 55, 0);

    wait_drained();
    program_regs(REG_INITIAL_COUNT, 8'd0, REG_MAX_COUNT, 8'd0);
    program_regs(REG_UNUSED_A, 8'hA5, REG_UNUSED_B, 8'h5A);
    send_gap_pct = 20;
    stall_pct    = 30;
    run_random(200, 60, 0);

    wait_drained();
    program_regs(REG_INITIAL_COUNT, 8'd1, REG_MAX_COUNT, 8'd1);
    send_gap_pct = 10;
    stall_pct    = 10;
    run_random(400, 55, 0);

    wait_drained();
    program_regs(REG_INITIAL_COUNT, 8'd0, REG_MAX_COUNT, 8'd16);
    send_gap_pct = 0;
    stall_pct    = 0;
    run_random(450, 60, 0);

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
